>>> rtl/battery_monitor_poll_top_macros.svh
// Assertion macros for the battery monitor poll block.
// Used by battery_monitor_poll_top; expects clk and arst_n in scope.
`ifndef BATTERY_MONITOR_POLL_TOP_MACROS_SVH
`define BATTERY_MONITOR_POLL_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define BMP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("battery monitor assertion failed");

// next-cycle implication, checked out of reset
`define BMP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("battery monitor assertion failed");

`endif

>>> rtl/bmp_pkg.sv
// Shared types and constants of the battery monitor poll block.
// No dependencies; used by the interfaces, the serial ALU and the top level.
package bmp_pkg;

	localparam int ALU_W = 42;

	localparam logic [2:0] REG_SCALE    = 3'd0;
	localparam logic [2:0] REG_VREF_TYP = 3'd1;
	localparam logic [2:0] REG_VREF_MIN = 3'd2;
	localparam logic [2:0] REG_SOC_CRIT = 3'd3;
	localparam logic [2:0] REG_SOC_LOW  = 3'd4;

	localparam logic [1:0] CS_ON_BATT  = 2'd0;
	localparam logic [1:0] CS_CHARGING = 2'd1;
	localparam logic [1:0] CS_DONE     = 2'd2;
	localparam logic [1:0] CS_STANDBY  = 2'd3;

	localparam logic [1:0] LED_IDLE     = 2'd0;
	localparam logic [1:0] LED_LOW      = 2'd1;
	localparam logic [1:0] LED_CRIT     = 2'd2;
	localparam logic [1:0] LED_CHARGING = 2'd3;

	localparam logic [7:0] SOC_NONE = 8'd255;

	// open-circuit voltage table, highest voltage first
	localparam logic [12:0] OCV_MV [0:10] = '{
		13'd4200, 13'd4100, 13'd4000, 13'd3900, 13'd3800, 13'd3700,
		13'd3600, 13'd3500, 13'd3400, 13'd3300, 13'd3000
	};
	localparam logic [6:0] OCV_SOC [0:10] = '{
		7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd35, 7'd20, 7'd10, 7'd5, 7'd0
	};

	typedef struct packed {
		logic [11:0] raw_vref;
		logic [14:0] batt_sum;
		logic [11:0] raw_temp;
		logic [11:0] raw_core;
		logic        core_ok;
		logic        pin_power_good;
		logic        pin_stat1;
		logic        pin_stat2;
		logic        pin_usb_sense;
	} in_item_t;

	typedef struct packed {
		logic [18:0]        batt_mv;
		logic [11:0]        batt_raw_avg;
		logic [7:0]         soc_pct;
		logic [1:0]         charge_state;
		logic               usb_present;
		logic signed [15:0] temp_x10;
		logic [15:0]        supply_mv;
		logic [15:0]        core_mv;
		logic [1:0]         led_level;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} alu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_rsp_t;

endpackage

>>> rtl/bmp_if.sv
// Valid/ready channel interfaces for poll items and result items.
// Depends on bmp_pkg for the payload types.
interface bmp_in_if;
	logic              valid;
	logic              ready;
	bmp_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bmp_out_if;
	logic               valid;
	logic               ready;
	bmp_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/bmp_serial_alu.sv
// Bit-serial multiply and restoring divide, one bit per cycle.
// Depends on bmp_pkg for the datapath width and request/response structs.
module bmp_serial_alu (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bmp_pkg::alu_req_t          req,
	input  logic [bmp_pkg::ALU_W-1:0]  a,
	input  logic [bmp_pkg::ALU_W-1:0]  b,
	output bmp_pkg::alu_rsp_t          rsp,
	output logic [bmp_pkg::ALU_W-1:0]  res
);
	import bmp_pkg::*;

	localparam int CW = $clog2(ALU_W);

	logic             busy_q;
	logic             done_q;
	logic             is_div_q;
	logic [CW-1:0]    cnt_q;
	logic [ALU_W-1:0] acc_q;
	logic [ALU_W-1:0] x_q;
	logic [ALU_W-1:0] y_q;
	logic [ALU_W:0]   trial;
	logic             fits;

	assign trial = {acc_q, x_q[ALU_W-1]};
	assign fits  = trial >= {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			is_div_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == CW'(ALU_W - 1));
			if (req.start) begin
				busy_q   <= 1'b1;
				is_div_q <= req.is_div;
				cnt_q    <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ALU_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			x_q   <= a;
			y_q   <= b;
		end else if (busy_q) begin
			if (is_div_q) begin
				// shift in the next dividend bit, subtract when the divisor fits
				if (fits) begin
					acc_q <= ALU_W'(trial - {1'b0, y_q});
				end else begin
					acc_q <= trial[ALU_W-1:0];
				end
				x_q <= {x_q[ALU_W-2:0], fits};
			end else begin
				if (y_q[0]) begin
					acc_q <= acc_q + x_q;
				end
				x_q <= {x_q[ALU_W-2:0], 1'b0};
				y_q <= {1'b0, y_q[ALU_W-1:1]};
			end
		end
	end

	assign res = is_div_q ? x_q : acc_q;
	assign rsp = '{busy: busy_q, done: done_q};

endmodule

>>> rtl/battery_monitor_poll_top.sv
// Battery monitor poll: one poll item in, one result item out.
// Channels: in_ch (poll readings and charger pins), out_ch (battery, SOC,
// temperature, supply, core, charger state, LED level), valid/ready each.
// Registers on an APB-style port: scale, reference nominal, reference
// minimum, critical and low SOC thresholds at byte addresses 0,4,8,12,16.
// The products and quotients of all passes run through one shared
// bit-serial unit (multiply or restoring divide) that takes one bit per
// cycle over a 42-bit word. An item needs up to ten passes (supply,
// average, two products and a divide for battery mV, core product and
// divide, temperature product and divide, SOC divide), and then the
// output register is loaded. A skipped supply or core update or an SOC
// outside the table moves on without its passes.
// One item is worked at a time; in_ch.ready is high only while idle.
// The result sits in an output register; if out_ch stalls, the next item
// may still be taken and worked, and its result waits for the register.
// Reset restores register defaults, supply 3300 mV and core 0 mV.
`include "battery_monitor_poll_top_macros.svh"

module battery_monitor_poll_top #(
	parameter int OVERSAMPLE_COUNT = 8,
	parameter int ADC_FULL_SCALE   = 4095
) (
	input  logic        clk,
	input  logic        arst_n,
	bmp_in_if.sink      in_ch,
	bmp_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bmp_pkg::*;

	localparam logic [ALU_W-1:0] FS_W    = ALU_W'(ADC_FULL_SCALE);
	localparam logic [ALU_W-1:0] OS_W    = ALU_W'(OVERSAMPLE_COUNT);
	localparam logic [ALU_W-1:0] MV_DIV  = ALU_W'(ADC_FULL_SCALE) * ALU_W'(1000);
	localparam logic [ALU_W-1:0] T_OFS   = ALU_W'(ADC_FULL_SCALE) * ALU_W'(2800);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SUP  = 4'd1;
	localparam logic [3:0] S_AVG  = 4'd2;
	localparam logic [3:0] S_M1   = 4'd3;
	localparam logic [3:0] S_M2   = 4'd4;
	localparam logic [3:0] S_DMV  = 4'd5;
	localparam logic [3:0] S_CMUL = 4'd6;
	localparam logic [3:0] S_CDIV = 4'd7;
	localparam logic [3:0] S_TMUL = 4'd8;
	localparam logic [3:0] S_TDIV = 4'd9;
	localparam logic [3:0] S_SOC  = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;

	logic [12:0] scale_q;
	logic [10:0] vtyp_q;
	logic [11:0] vmin_q;
	logic [6:0]  crit_q;
	logic [6:0]  low_q;

	logic [3:0]         state_q;
	logic               pend_q;
	in_item_t           in_q;
	logic [15:0]        supply_q;
	logic [15:0]        core_q;
	logic [11:0]        avg_q;
	logic [18:0]        mv_q;
	logic [ALU_W-1:0]   t_q;
	logic               tneg_q;
	logic signed [15:0] temp_q;
	logic [7:0]         soc_q;
	out_item_t          out_q;
	logic               out_valid_q;

	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;
	logic [ALU_W-1:0] alu_a;
	logic [ALU_W-1:0] alu_b;
	logic [ALU_W-1:0] alu_res;
	logic             skip;

	logic             cfg_wr;
	logic [2:0]       cfg_idx;

	// SOC segment
	logic [12:0]      vlo;
	logic [12:0]      vhi;
	logic [6:0]       slo;
	logic [6:0]       shi;
	logic [8:0]       span;
	logic [8:0]       dv;
	logic [3:0]       ds;
	logic [13:0]      soc_num;
	logic             soc_hi;
	logic             soc_lo;

	logic [ALU_W-1:0] p5;
	logic [1:0]       chg;
	logic [7:0]       soc_fin;
	logic [1:0]       led;

	// ---------------- configuration port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 13'd2000;
			vtyp_q  <= 11'd1212;
			vmin_q  <= 12'd100;
			crit_q  <= 7'd5;
			low_q   <= 7'd20;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_SCALE:    scale_q <= pwdata[12:0];
				REG_VREF_TYP: vtyp_q  <= pwdata[10:0];
				REG_VREF_MIN: vmin_q  <= pwdata[11:0];
				REG_SOC_CRIT: crit_q  <= pwdata[6:0];
				REG_SOC_LOW:  low_q   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_SCALE:    prdata = 32'(scale_q);
			REG_VREF_TYP: prdata = 32'(vtyp_q);
			REG_VREF_MIN: prdata = 32'(vmin_q);
			REG_SOC_CRIT: prdata = 32'(crit_q);
			REG_SOC_LOW:  prdata = 32'(low_q);
			default:      prdata = '0;
		endcase
	end

	// ---------------- SOC segment select
	always_comb begin
		vlo = OCV_MV[10];
		vhi = OCV_MV[9];
		slo = OCV_SOC[10];
		shi = OCV_SOC[9];
		for (int i = 9; i >= 0; i--) begin
			if (mv_q >= 19'(OCV_MV[i+1])) begin
				vlo = OCV_MV[i+1];
				vhi = OCV_MV[i];
				slo = OCV_SOC[i+1];
				shi = OCV_SOC[i];
			end
		end
		span    = 9'(vhi - vlo);
		dv      = 9'(mv_q - 19'(vlo));
		ds      = 4'(shi - slo);
		soc_num = 14'({dv, 1'b0}) * 14'(ds) + 14'(span);
		soc_hi  = mv_q >= 19'(OCV_MV[0]);
		soc_lo  = mv_q <= 19'(OCV_MV[10]);
	end

	// ---------------- ALU operand select
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_req.is_div = 1'b0;
		skip = 1'b0;
		case (state_q)
			S_SUP: begin
				alu_a = ALU_W'(vtyp_q) * FS_W;
				alu_b = ALU_W'(in_q.raw_vref);
				alu_req.is_div = 1'b1;
				skip = in_q.raw_vref <= vmin_q;
			end
			S_AVG: begin
				alu_a = ALU_W'(in_q.batt_sum);
				alu_b = OS_W;
				alu_req.is_div = 1'b1;
			end
			S_M1: begin
				alu_a = ALU_W'(avg_q);
				alu_b = ALU_W'(supply_q);
			end
			S_M2: begin
				alu_a = t_q;
				alu_b = ALU_W'(scale_q);
			end
			S_DMV: begin
				alu_a = t_q;
				alu_b = MV_DIV;
				alu_req.is_div = 1'b1;
			end
			S_CMUL: begin
				alu_a = ALU_W'(in_q.raw_core);
				alu_b = ALU_W'(supply_q);
				skip = !in_q.core_ok;
			end
			S_CDIV: begin
				alu_a = t_q;
				alu_b = FS_W;
				alu_req.is_div = 1'b1;
			end
			S_TMUL: begin
				alu_a = ALU_W'(in_q.raw_temp);
				alu_b = ALU_W'(supply_q);
			end
			S_TDIV: begin
				alu_a = t_q;
				alu_b = FS_W;
				alu_req.is_div = 1'b1;
			end
			S_SOC: begin
				alu_a = ALU_W'(soc_num);
				alu_b = ALU_W'({span, 1'b0});
				alu_req.is_div = 1'b1;
				skip = soc_hi || soc_lo;
			end
			default: ;
		endcase
		alu_req.start = !pend_q && !skip && state_q != S_IDLE && state_q != S_FIN;
	end

	bmp_serial_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (alu_a),
		.b      (alu_b),
		.rsp    (alu_rsp),
		.res    (alu_res)
	);

	assign p5 = {alu_res[ALU_W-3:0], 2'b00} + alu_res;

	// ---------------- charger decode and LED
	always_comb begin
		if (in_q.pin_power_good) begin
			chg = CS_ON_BATT;
		end else if (!in_q.pin_stat1 && in_q.pin_stat2) begin
			chg = CS_CHARGING;
		end else if (in_q.pin_stat1 && !in_q.pin_stat2) begin
			chg = CS_DONE;
		end else begin
			chg = CS_STANDBY;
		end
		soc_fin = (chg == CS_CHARGING) ? SOC_NONE : soc_q;
		if (chg == CS_CHARGING) begin
			led = LED_CHARGING;
		end else if (soc_fin <= 8'(crit_q)) begin
			led = LED_CRIT;
		end else if (soc_fin <= 8'(low_q)) begin
			led = LED_LOW;
		end else begin
			led = LED_IDLE;
		end
	end

	// ---------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			supply_q    <= 16'd3300;
			core_q      <= 16'd0;
			avg_q       <= '0;
			mv_q        <= '0;
			t_q         <= '0;
			tneg_q      <= 1'b0;
			temp_q      <= '0;
			soc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (alu_req.start) begin
				pend_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						state_q <= S_SUP;
					end
				end
				S_SUP: begin
					if (skip) begin
						state_q <= S_AVG;
					end else if (pend_q && alu_rsp.done) begin
						pend_q   <= 1'b0;
						supply_q <= (|alu_res[ALU_W-1:16]) ? 16'hFFFF : alu_res[15:0];
						state_q  <= S_AVG;
					end
				end
				S_AVG: begin
					if (pend_q && alu_rsp.done) begin
						pend_q  <= 1'b0;
						avg_q   <= (|alu_res[ALU_W-1:12]) ? 12'hFFF : alu_res[11:0];
						state_q <= S_M1;
					end
				end
				S_M1, S_M2: begin
					if (pend_q && alu_rsp.done) begin
						pend_q  <= 1'b0;
						t_q     <= alu_res;
						state_q <= (state_q == S_M1) ? S_M2 : S_DMV;
					end
				end
				S_DMV: begin
					if (pend_q && alu_rsp.done) begin
						pend_q  <= 1'b0;
						mv_q    <= (|alu_res[ALU_W-1:19]) ? 19'h7FFFF : alu_res[18:0];
						state_q <= S_CMUL;
					end
				end
				S_CMUL: begin
					if (skip) begin
						state_q <= S_TMUL;
					end else if (pend_q && alu_rsp.done) begin
						pend_q  <= 1'b0;
						t_q     <= alu_res;
						state_q <= S_CDIV;
					end
				end
				S_CDIV: begin
					if (pend_q && alu_rsp.done) begin
						pend_q  <= 1'b0;
						core_q  <= (|alu_res[ALU_W-1:16]) ? 16'hFFFF : alu_res[15:0];
						state_q <= S_TMUL;
					end
				end
				S_TMUL: begin
					if (pend_q && alu_rsp.done) begin
						// fold 5*raw*supply minus the offset into sign and magnitude
						pend_q <= 1'b0;
						if (p5 >= T_OFS) begin
							tneg_q <= 1'b0;
							t_q    <= p5 - T_OFS;
						end else begin
							tneg_q <= 1'b1;
							t_q    <= T_OFS - p5;
						end
						state_q <= S_TDIV;
					end
				end
				S_TDIV: begin
					if (pend_q && alu_rsp.done) begin
						pend_q <= 1'b0;
						if (tneg_q) begin
							temp_q <= (alu_res >= ALU_W'(32768)) ? 16'sh8000
								: -$signed(alu_res[15:0]);
						end else begin
							temp_q <= (alu_res > ALU_W'(32767)) ? 16'sh7FFF
								: $signed(alu_res[15:0]);
						end
						state_q <= S_SOC;
					end
				end
				S_SOC: begin
					if (skip) begin
						soc_q   <= soc_hi ? 8'(OCV_SOC[0]) : 8'(OCV_SOC[10]);
						state_q <= S_FIN;
					end else if (pend_q && alu_rsp.done) begin
						pend_q  <= 1'b0;
						soc_q   <= 8'(slo) + alu_res[7:0];
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// hold until the output register is free
					if (!out_valid_q || out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			in_q <= in_ch.data;
		end
		if (state_q == S_FIN && (!out_valid_q || out_ch.ready)) begin
			out_q.batt_mv      <= mv_q;
			out_q.batt_raw_avg <= avg_q;
			out_q.soc_pct      <= soc_fin;
			out_q.charge_state <= chg;
			out_q.usb_present  <= in_q.pin_usb_sense;
			out_q.temp_x10     <= temp_q;
			out_q.supply_mv    <= supply_q;
			out_q.core_mv      <= core_q;
			out_q.led_level    <= led;
		end
	end

	assign in_ch.ready  = (state_q == S_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	`BMP_ASSERT_NEXT(a_accept_starts, in_ch.valid && in_ch.ready, state_q == S_SUP)
	`BMP_ASSERT_NOW(a_idle_no_pend, state_q == S_IDLE, !pend_q && !alu_rsp.busy)
	`BMP_ASSERT_NOW(a_charging_out, out_ch.valid && out_ch.data.charge_state == CS_CHARGING,
		out_ch.data.soc_pct == SOC_NONE && out_ch.data.led_level == LED_CHARGING)
	`BMP_ASSERT_NOW(a_soc_range, out_ch.valid && out_ch.data.charge_state != CS_CHARGING,
		out_ch.data.soc_pct <= 8'd100)

endmodule

>>> tb/sv/bmp_poll_checker.sv
`timescale 1ns / 1ps
// Result checker for battery_monitor_poll_top: mirrors the register writes,
// predicts each poll result and compares it with the out channel.
// Depends on bmp_pkg and the channel interfaces in bmp_if.
module bmp_poll_checker (
	input  logic        clk,
	input  logic        arst_n,
	bmp_in_if           in_mon,
	bmp_out_if          out_mon,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending
);
	import bmp_pkg::*;

	localparam longint FULL_SCALE = 4095;
	localparam longint OVERSAMPLE = 8;

	logic [12:0] scale_permille;
	logic [10:0] vref_typ_mv;
	logic [11:0] vref_min;
	logic [6:0]  soc_crit;
	logic [6:0]  soc_low;
	logic [15:0] supply_mv;
	logic [15:0] core_mv;

	out_item_t expected_results[$];

	function automatic logic [7:0] soc_from_mv(longint mv);
		longint span, ds, num;
		if (mv >= OCV_MV[0])
			return 8'(OCV_SOC[0]);
		if (mv <= OCV_MV[10])
			return 8'(OCV_SOC[10]);
		for (int i = 0; i < 10; i++) begin
			if (mv >= OCV_MV[i+1]) begin
				span = OCV_MV[i] - OCV_MV[i+1];
				ds = OCV_SOC[i] - OCV_SOC[i+1];
				num = 2 * (mv - OCV_MV[i+1]) * ds + span;
				return 8'(OCV_SOC[i+1] + num / (2 * span));
			end
		end
		return 8'd0;
	endfunction

	// work out one poll result; supply and core state are updated in place
	function automatic out_item_t predict_poll(in_item_t it, inout logic [15:0] sup,
			inout logic [15:0] core);
		out_item_t r;
		longint q, avg, mv, tnum;
		if (it.raw_vref > vref_min && it.raw_vref != 0) begin
			q = longint'(vref_typ_mv) * FULL_SCALE / longint'(it.raw_vref);
			sup = (q > 65535) ? 16'hFFFF : q[15:0];
		end
		avg = longint'(it.batt_sum) / OVERSAMPLE;
		if (avg > 4095)
			avg = 4095;
		mv = avg * longint'(sup) * longint'(scale_permille) / (FULL_SCALE * 1000);
		if (mv > 524287)
			mv = 524287;
		if (it.core_ok) begin
			q = longint'(it.raw_core) * longint'(sup) / FULL_SCALE;
			core = (q > 65535) ? 16'hFFFF : q[15:0];
		end
		if (it.pin_power_good)
			r.charge_state = CS_ON_BATT;
		else if (!it.pin_stat1 && it.pin_stat2)
			r.charge_state = CS_CHARGING;
		else if (it.pin_stat1 && !it.pin_stat2)
			r.charge_state = CS_DONE;
		else
			r.charge_state = CS_STANDBY;
		r.soc_pct = (r.charge_state == CS_CHARGING) ? SOC_NONE : soc_from_mv(mv);
		if (r.charge_state == CS_CHARGING)
			r.led_level = LED_CHARGING;
		else if (r.soc_pct <= soc_crit)
			r.led_level = LED_CRIT;
		else if (r.soc_pct <= soc_low)
			r.led_level = LED_LOW;
		else
			r.led_level = LED_IDLE;
		// signed division truncates toward zero
		tnum = 5 * longint'(it.raw_temp) * longint'(sup) - 2800 * FULL_SCALE;
		q = tnum / FULL_SCALE;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		r.temp_x10 = q[15:0];
		r.batt_mv = mv[18:0];
		r.batt_raw_avg = avg[11:0];
		r.usb_present = it.pin_usb_sense;
		r.supply_mv = sup;
		r.core_mv = core;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t e, a;
		logic [15:0] sup, core;
		if (!arst_n) begin
			scale_permille <= 13'd2000;
			vref_typ_mv <= 11'd1212;
			vref_min <= 12'd100;
			soc_crit <= 7'd5;
			soc_low <= 7'd20;
			supply_mv <= 16'd3300;
			core_mv <= 16'd0;
			fail_count <= 0;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_SCALE:    scale_permille <= pwdata[12:0];
					REG_VREF_TYP: vref_typ_mv <= pwdata[10:0];
					REG_VREF_MIN: vref_min <= pwdata[11:0];
					REG_SOC_CRIT: soc_crit <= pwdata[6:0];
					REG_SOC_LOW:  soc_low <= pwdata[6:0];
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready) begin
				sup = supply_mv;
				core = core_mv;
				expected_results.push_back(predict_poll(in_mon.data, sup, core));
				supply_mv <= sup;
				core_mv <= core;
			end
			if (out_mon.valid && out_mon.ready) begin
				a = out_mon.data;
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result item: %p", a);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_results.pop_front();
					if (a.batt_mv !== e.batt_mv || a.batt_raw_avg !== e.batt_raw_avg
							|| a.soc_pct !== e.soc_pct || a.charge_state !== e.charge_state
							|| a.usb_present !== e.usb_present || a.temp_x10 !== e.temp_x10
							|| a.supply_mv !== e.supply_mv || a.core_mv !== e.core_mv
							|| a.led_level !== e.led_level) begin
						if (fail_count < 10)
							$display("result mismatch at %0t\n  exp %p\n  got %p", $realtime, e, a);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_results.size();
		end
	end

endmodule

>>> tb/sv/tb_battery_monitor_poll_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for battery_monitor_poll_top: register phases, poll
// items with random gaps and stalls; checking is done in bmp_poll_checker.
// Depends on bmp_pkg, bmp_if and the block.
module tb_battery_monitor_poll_top;
	import bmp_pkg::*;

	localparam int CYCLE_LIMIT = 6000000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count, pending;
	bit          jitter_on;
	bit          sink_hold_req;

	bmp_in_if  in_ch ();
	bmp_out_if out_ch ();

	battery_monitor_poll_top uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	bmp_poll_checker poll_chk (
		.clk(clk), .arst_n(arst_n), .in_mon(in_ch), .out_mon(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus one long hold on request
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold_req) begin
				out_ch.ready = 1'b0;
				repeat (3000) @(negedge clk);
				sink_hold_req = 1'b0;
			end
			out_ch.ready = !(jitter_on && $urandom_range(99) < 24);
		end
	end

	task automatic apb_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// drop valid so nothing more is taken, then wait out every result
	task automatic drain();
		in_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_limits(int scale, int vtyp, int vmin, int crit, int low);
		drain();
		apb_write(REG_SCALE, scale);
		apb_write(REG_VREF_TYP, vtyp);
		apb_write(REG_VREF_MIN, vmin);
		apb_write(REG_SOC_CRIT, crit);
		apb_write(REG_SOC_LOW, low);
	endtask

	// called and returning at a falling edge; valid stays high across items unless a random gap drops it
	task automatic send_poll(in_item_t it);
		if (jitter_on && $urandom_range(99) < 24) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data = it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic in_item_t poll(int vref, int bsum, int temp, int core, bit ok,
			logic [3:0] pins);
		in_item_t it;
		it.raw_vref = 12'(vref);
		it.batt_sum = 15'(bsum);
		it.raw_temp = 12'(temp);
		it.raw_core = 12'(core);
		it.core_ok = ok;
		{it.pin_power_good, it.pin_stat1, it.pin_stat2, it.pin_usb_sense} = pins;
		return it;
	endfunction

	function automatic in_item_t random_poll();
		in_item_t it;
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		it = bits[$bits(in_item_t)-1:0];
		// keep raw_vref near nominal most of the time so battery mV hits the table
		if ($urandom_range(3) != 0)
			it.raw_vref = 12'($urandom_range(1300, 1700));
		if ($urandom_range(1) == 0)
			it.batt_sum = 15'($urandom_range(12000, 24000));
		else
			it.batt_sum = 15'($urandom_range(32760));
		return it;
	endfunction

	task automatic random_run(int n);
		repeat (n) send_poll(random_poll());
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		jitter_on = 1'b0;
		sink_hold_req = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: thresholds, extremes, every charger pin pair
		send_poll(poll(0, 0, 0, 0, 1'b1, 4'b1000));
		send_poll(poll(100, 16000, 2000, 2000, 1'b1, 4'b1000));
		send_poll(poll(101, 16000, 2000, 2000, 1'b0, 4'b1000));
		send_poll(poll(1, 32760, 4095, 4095, 1'b1, 4'b1001));
		send_poll(poll(4095, 32760, 4095, 4095, 1'b1, 4'b0000));
		send_poll(poll(1500, 0, 0, 0, 1'b1, 4'b0011));
		send_poll(poll(1500, 16000, 1000, 4095, 1'b1, 4'b0010));
		send_poll(poll(1500, 18000, 1000, 1, 1'b0, 4'b0101));
		send_poll(poll(1500, 20000, 1000, 1, 1'b1, 4'b0111));
		send_poll(poll(1500, 22000, 1000, 1, 1'b1, 4'b1111));
		send_poll(poll(1500, 24000, 3000, 1, 1'b1, 4'b1110));
		send_poll(poll(1500, 14880, 3000, 1, 1'b1, 4'b0100));
		send_poll(poll(1500, 15000, 3000, 1, 1'b1, 4'b0000));
		send_poll(poll(1500, 17000, 3000, 1, 1'b1, 4'b0000));
		send_poll(poll(1500, 19500, 3000, 1, 1'b1, 4'b0000));
		send_poll(poll(1500, 21000, 3000, 1, 1'b1, 4'b0000));
		send_poll(poll(1500, 23500, 3000, 1, 1'b1, 4'b0000));
		send_poll(poll(4095, 20000, 0, 0, 1'b1, 4'b1100));

		// no idling on either side
		random_run(150);

		jitter_on = 1'b1;
		random_run(250);

		// long receiver hold while items keep coming
		sink_hold_req = 1'b1;
		random_run(60);

		set_limits(1000, 1000, 0, 0, 0);
		random_run(200);
		set_limits(8000, 1400, 4095, 100, 100);
		random_run(150);
		set_limits(8000, 1400, 0, 50, 90);
		random_run(200);
		set_limits($urandom_range(1000, 8000), $urandom_range(1000, 1400),
			$urandom_range(0, 200), $urandom_range(0, 30), $urandom_range(10, 60));
		random_run(200);
		set_limits(2000, 1212, 100, 5, 20);
		random_run(300);

		in_ch.valid = 1'b0;
		drain();
		repeat (500) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> battery_monitor_poll_top.f
+incdir+rtl
rtl/bmp_pkg.sv
rtl/bmp_if.sv
rtl/bmp_serial_alu.sv
rtl/battery_monitor_poll_top.sv
tb/sv/bmp_poll_checker.sv
tb/sv/tb_battery_monitor_poll_top.sv
